/* rtl/core/cpsld_pkg.sv */
// Shared codes, widths and types for the curve point store with loop-back detection.
`default_nettype none

package cpsld_pkg;

	localparam int REQ_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int GAP_W      = 11;
	localparam int THR_W      = 50;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 50;

	localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

	localparam logic [STATUS_W-1:0] STS_APPENDED = 3'd0;
	localparam logic [STATUS_W-1:0] STS_LOOPED   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STS_REVERSED = 3'd3;
	localparam logic [STATUS_W-1:0] STS_READ_OK  = 3'd4;
	localparam logic [STATUS_W-1:0] STS_READ_OOR = 3'd5;

	localparam logic [CFG_ADDR_W-1:0] REG_LOOP_ENABLE   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_INDEX_GAP = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_LOOP_DIST_SQ  = 2'd2;

	typedef struct packed {
		logic valid;
		logic hit;
	} dist_res_t;

endpackage

`default_nettype wire

/* rtl/core/cpsld_mem.sv */
// Point store memory: one write port, one registered read port.
`default_nettype none

module cpsld_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 72
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/cpsld_dist.sv */
// Pipelined squared-distance compare unit, one stored point per cycle.
`default_nettype none

module cpsld_dist import cpsld_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         flush,
	input  wire logic                         in_valid,
	input  wire logic signed [COORD_BITS-1:0] pt_x,
	input  wire logic signed [COORD_BITS-1:0] pt_y,
	input  wire logic signed [COORD_BITS-1:0] pt_z,
	input  wire logic signed [COORD_BITS-1:0] q_x,
	input  wire logic signed [COORD_BITS-1:0] q_y,
	input  wire logic signed [COORD_BITS-1:0] q_z,
	input  wire logic        [THR_W-1:0]      thr,
	output dist_res_t                         res,
	output logic signed      [COORD_BITS-1:0] hit_x,
	output logic signed      [COORD_BITS-1:0] hit_y,
	output logic signed      [COORD_BITS-1:0] hit_z
);

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		logic        [COORD_BITS:0] m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[COORD_BITS] ? (~d + 1'b1) : d;
		return m[COORD_BITS-1:0];
	endfunction

	logic                         v_s1, v_s2, v_s3;
	logic        [COORD_BITS-1:0] ax_s1, ay_s1, az_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, pz_s1;
	logic        [SQ_W-1:0]       sx_s2, sy_s2, sz_s2;
	logic signed [COORD_BITS-1:0] px_s2, py_s2, pz_s2;
	logic                         hit_s3;
	logic signed [COORD_BITS-1:0] px_s3, py_s3, pz_s3;
	logic        [SUM_W-1:0]      sum;

	assign sum = SUM_W'(sx_s2) + SUM_W'(sy_s2) + SUM_W'(sz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid & ~flush;
			v_s2 <= v_s1 & ~flush;
			v_s3 <= v_s2 & ~flush;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= abs_diff(pt_x, q_x);
		ay_s1  <= abs_diff(pt_y, q_y);
		az_s1  <= abs_diff(pt_z, q_z);
		px_s1  <= pt_x;
		py_s1  <= pt_y;
		pz_s1  <= pt_z;
		sx_s2  <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
		sy_s2  <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
		sz_s2  <= SQ_W'(az_s1) * SQ_W'(az_s1);
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		pz_s2  <= pz_s1;
		hit_s3 <= CMP_W'(sum) < CMP_W'(thr);
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		pz_s3  <= pz_s2;
	end

	assign res.valid = v_s3;
	assign res.hit   = hit_s3;
	assign hit_x     = px_s3;
	assign hit_y     = py_s3;
	assign hit_z     = pz_s3;

endmodule

`default_nettype wire

/* rtl/core/curve_point_store_loop_detect_core.sv */
// Top level: request sequencer, ring store control, config registers and output register.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------------------
//  s_      | in  | tvalid/tready    | tuser: req_type; tdata: read_index, pos_x, pos_y, pos_z
//  m_      | out | tvalid/tready    | tuser: status; tdata: match_index, point_count, xyz
//  cfg_    | in  | we (no wait)     | addr: register index; data: register value
//
// One item at a time; s_tready is high only while idle.
// Add without search goes through the append state to the final state. Add with search
// over older points: one point per cycle through the distance pipeline; stops at
// the first hit. Read in range: read and read-data states; any other request: final state.
// A result waiting on m_tready holds the sequencer in its final state.
// Reset clears count, ring head, order bit and registers; store contents are not cleared.
`default_nettype none

module curve_point_store_loop_detect_core import cpsld_pkg::*; #(
	parameter int DEPTH      = 1024,
	parameter int COORD_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// req_type
	input  wire logic [REQ_W-1:0]      s_tuser,
	// read_index, pos_x, pos_y, pos_z
	input  wire logic [((IDX_W+3*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// status
	output logic      [STATUS_W-1:0]   m_tuser,
	// match_index, point_count, out_x, out_y, out_z
	output logic      [((IDX_W+CNT_W+3*COORD_BITS+7)/8)*8-1:0] m_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW          = $clog2(DEPTH);
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int CMPW        = (CW > GAP_W) ? CW : GAP_W;
	localparam int OUT_TDATA_W = ((IDX_W + CNT_W + 3 * COORD_BITS + 7) / 8) * 8;
	localparam int PW          = 3 * COORD_BITS;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_RDATA  = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    head_q;
	logic             rev_q;
	logic             loop_en_q;
	logic [GAP_W-1:0] gap_q;
	logic [THR_W-1:0] thr_q;
	logic             out_valid_q;
	logic             scan_rd_q;
	logic [CW-1:0]    issue_idx_q;
	logic [CW-1:0]    ret_cnt_q;

	logic [CW-1:0]                lim_q;
	logic [CW-1:0]                match_q;
	logic [IDX_W-1:0]             ridx_q;
	logic [STATUS_W-1:0]          sts_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
	logic signed [COORD_BITS-1:0] rx_q, ry_q, rz_q;
	logic [OUT_TDATA_W-1:0]       m_tdata_q;
	logic [STATUS_W-1:0]          m_tuser_q;

	logic [IDX_W-1:0]             in_ridx;
	logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
	logic [CMPW-1:0]              count_ext, gap_ext;
	logic                         accept, issue, hit_seen, last_miss, out_free;
	logic [CW-1:0]                log_idx, off;
	logic [CW:0]                  psum, wsum;
	logic [AW-1:0]                rd_addr, wr_addr, head_dec, wmod;
	logic                         rd_en, wr_en;
	logic [PW-1:0]                rdata;
	dist_res_t                    res;
	logic signed [COORD_BITS-1:0] hit_x, hit_y, hit_z;

	assign in_ridx = s_tdata[IDX_W-1:0];
	assign in_x    = s_tdata[IDX_W +: COORD_BITS];
	assign in_y    = s_tdata[IDX_W+COORD_BITS +: COORD_BITS];
	assign in_z    = s_tdata[IDX_W+2*COORD_BITS +: COORD_BITS];

	assign count_ext = CMPW'(count_q);
	assign gap_ext   = CMPW'(gap_q);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign hit_seen  = (state_q == S_SCAN) & res.valid & res.hit;
	assign last_miss = (state_q == S_SCAN) & res.valid & ~res.hit
		& ((ret_cnt_q + CW'(1)) == lim_q);
	assign issue     = (state_q == S_SCAN) & (issue_idx_q < lim_q) & ~hit_seen;
	assign out_free  = ~out_valid_q | m_tready;

	// logical position to physical slot
	assign log_idx = (state_q == S_READ) ? CW'(ridx_q) : issue_idx_q;
	assign off     = rev_q ? CW'(count_q - CW'(1) - log_idx) : log_idx;
	assign psum    = (CW+1)'(head_q) + (CW+1)'(off);
	assign rd_addr = (psum >= (CW+1)'(DEPTH)) ? AW'(psum - (CW+1)'(DEPTH)) : AW'(psum);
	assign rd_en   = issue | (state_q == S_READ);

	// append slot
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : AW'(head_q - AW'(1));
	assign wsum     = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign wmod     = (wsum >= (CW+1)'(DEPTH)) ? AW'(wsum - (CW+1)'(DEPTH)) : AW'(wsum);
	assign wr_addr  = rev_q ? head_dec : wmod;
	assign wr_en    = (state_q == S_APPEND);

	cpsld_mem #(
		.DEPTH (DEPTH),
		.WIDTH (PW)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata ({rz_q, ry_q, rx_q}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	cpsld_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (hit_seen),
		.in_valid (scan_rd_q),
		.pt_x     (rdata[0 +: COORD_BITS]),
		.pt_y     (rdata[COORD_BITS +: COORD_BITS]),
		.pt_z     (rdata[2*COORD_BITS +: COORD_BITS]),
		.q_x      (qx_q),
		.q_y      (qy_q),
		.q_z      (qz_q),
		.thr      (thr_q),
		.res      (res),
		.hit_x    (hit_x),
		.hit_y    (hit_y),
		.hit_z    (hit_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_en_q <= 1'b0;
			gap_q     <= '0;
			thr_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LOOP_ENABLE:   loop_en_q <= cfg_data[0];
				REG_MIN_INDEX_GAP: gap_q     <= cfg_data[GAP_W-1:0];
				REG_LOOP_DIST_SQ:  thr_q     <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
			scan_rd_q   <= 1'b0;
			issue_idx_q <= '0;
			ret_cnt_q   <= '0;
		end else begin
			scan_rd_q <= issue;
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						issue_idx_q <= '0;
						ret_cnt_q   <= '0;
						case (s_tuser)
							REQ_ADD: begin
								if (count_q == CW'(DEPTH)) begin
									state_q <= S_FIN;
								end else if (loop_en_q && (count_ext > gap_ext)) begin
									state_q <= S_SCAN;
								end else begin
									state_q <= S_APPEND;
								end
							end
							REQ_REVERSE: begin
								if (count_q != '0) begin
									rev_q <= ~rev_q;
								end
								state_q <= S_FIN;
							end
							REQ_READ: begin
								if (CMPW'(in_ridx) < count_ext) begin
									state_q <= S_READ;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						issue_idx_q <= issue_idx_q + CW'(1);
					end
					if (res.valid) begin
						ret_cnt_q <= ret_cnt_q + CW'(1);
					end
					if (hit_seen || last_miss) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (rev_q) begin
						head_q <= head_dec;
					end
					count_q <= count_q + CW'(1);
					state_q <= S_FIN;
				end
				S_READ:  state_q <= S_RDATA;
				S_RDATA: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ridx_q  <= in_ridx;
					qx_q    <= in_x;
					qy_q    <= in_y;
					qz_q    <= in_z;
					match_q <= '0;
					lim_q   <= CW'(count_ext - gap_ext);
					rx_q    <= '0;
					ry_q    <= '0;
					rz_q    <= '0;
					case (s_tuser)
						REQ_ADD: begin
							if (count_q == CW'(DEPTH)) begin
								sts_q <= STS_FULL;
							end else begin
								sts_q <= STS_APPENDED;
								rx_q  <= in_x;
								ry_q  <= in_y;
								rz_q  <= in_z;
							end
						end
						REQ_REVERSE: sts_q <= STS_REVERSED;
						default:     sts_q <= STS_READ_OOR;
					endcase
				end
			end
			S_SCAN: begin
				if (hit_seen) begin
					sts_q   <= STS_LOOPED;
					match_q <= ret_cnt_q;
					rx_q    <= hit_x;
					ry_q    <= hit_y;
					rz_q    <= hit_z;
				end
			end
			S_RDATA: begin
				sts_q <= STS_READ_OK;
				rx_q  <= rdata[0 +: COORD_BITS];
				ry_q  <= rdata[COORD_BITS +: COORD_BITS];
				rz_q  <= rdata[2*COORD_BITS +: COORD_BITS];
			end
			S_FIN: begin
				if (out_free) begin
					m_tuser_q <= sts_q;
					m_tdata_q <= OUT_TDATA_W'({rz_q, ry_q, rx_q,
						CNT_W'(count_q), IDX_W'(match_q)});
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

/* rtl/core/cpsld_chk.sv */
// Port-level checker for the curve point store core, with its bind.
`default_nettype none

module cpsld_chk import cpsld_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [STATUS_W-1:0]   m_tuser,
	input wire logic [((IDX_W+CNT_W+3*COORD_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int XYZ_LO = IDX_W + CNT_W;
	localparam int XYZ_W  = 3 * COORD_BITS;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready high right after an accepted item");

	a_match_only_on_loop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STS_LOOPED) |-> m_tdata[IDX_W-1:0] == '0)
		else $error("match index set without loop-back");

	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STS_FULL || m_tuser == STS_REVERSED
			|| m_tuser == STS_READ_OOR) |-> m_tdata[XYZ_LO +: XYZ_W] == '0)
		else $error("nonzero point on a result without one");

endmodule

bind curve_point_store_loop_detect_core cpsld_chk #(
	.COORD_BITS (COORD_BITS)
) u_cpsld_chk (.*);

`default_nettype wire

/* bench/tb_curve_point_store_loop_detect_core.sv */
// Testbench for curve_point_store_loop_detect_core: queued stimulus, store predictor, checks.
`timescale 1ns / 1ps

module tb_curve_point_store_loop_detect_core import cpsld_pkg::*;;

	localparam int DEPTH = 1024;
	localparam int CW = 24;
	localparam int S_W = ((IDX_W + 3 * CW + 7) / 8) * 8;
	localparam int M_W = ((IDX_W + CNT_W + 3 * CW + 7) / 8) * 8;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [CW-1:0] CMAX = 24'h7FFFFF;
	localparam logic [CW-1:0] CMIN = 24'h800000;
	localparam longint unsigned THR_MAX = 64'd3 << 48;
	localparam int HOLD_LEN = 400;
	localparam int LIMIT = 6000000;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} point_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic [IDX_W-1:0] ridx;
		logic [CW-1:0]    x;
		logic [CW-1:0]    y;
		logic [CW-1:0]    z;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    match;
		logic [CNT_W-1:0]    count;
		logic [CW-1:0]       x;
		logic [CW-1:0]       y;
		logic [CW-1:0]       z;
	} store_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [REQ_W-1:0] s_tuser = '0;
	logic [S_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [STATUS_W-1:0] m_tuser;
	logic [M_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic [CW-1:0] mem_x [DEPTH];
	logic [CW-1:0] mem_y [DEPTH];
	logic [CW-1:0] mem_z [DEPTH];
	int pt_count = 0;
	int pt_head = 0;
	bit pt_rev = 1'b0;
	bit cfg_loop = 1'b0;
	int cfg_gap = 0;
	longint unsigned cfg_thr = 0;

	req_item_t item_q[$];
	store_answer_t answer_q[$];
	point_t seen_q[$];
	req_item_t cur_item;
	int plan_count = 0;
	int items_pushed = 0;
	int items_taken = 0;
	int results_seen = 0;
	int errors = 0;
	int cycles = 0;
	bit item_taken = 1'b0;
	bit quiet = 1'b0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;

	curve_point_store_loop_detect_core #(
		.DEPTH(DEPTH),
		.COORD_BITS(CW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int slot_of(int pos);
		if (pt_rev)
			return (pt_head + pt_count - 1 - pos) % DEPTH;
		return (pt_head + pos) % DEPTH;
	endfunction

	// 24-bit coordinates keep the sum below 2^50, so no saturation is reachable
	function automatic longint unsigned dist_sq(
		input logic signed [CW-1:0] ax, ay, az, bx, by, bz);
		longint dx, dy, dz;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		dz = longint'(az) - longint'(bz);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	task automatic advance_store(input req_item_t it, output store_answer_t a);
		int lim, p, slot;
		bit hit;
		a = '0;
		a.status = STS_READ_OOR;
		hit = 1'b0;
		case (it.req)
			REQ_ADD: begin
				if (pt_count >= DEPTH) begin
					a.status = STS_FULL;
				end else begin
					if (cfg_loop && pt_count >= cfg_gap) begin
						lim = pt_count - cfg_gap;
						for (int i = 0; i < lim && !hit; i++) begin
							p = slot_of(i);
							if (dist_sq(mem_x[p], mem_y[p], mem_z[p],
								it.x, it.y, it.z) < cfg_thr) begin
								hit = 1'b1;
								a.match = IDX_W'(i);
								a.x = mem_x[p];
								a.y = mem_y[p];
								a.z = mem_z[p];
							end
						end
					end
					if (hit) begin
						a.status = STS_LOOPED;
					end else begin
						a.status = STS_APPENDED;
						a.x = it.x;
						a.y = it.y;
						a.z = it.z;
					end
					if (pt_rev) begin
						pt_head = (pt_head + DEPTH - 1) % DEPTH;
						slot = pt_head;
					end else begin
						slot = (pt_head + pt_count) % DEPTH;
					end
					mem_x[slot] = a.x;
					mem_y[slot] = a.y;
					mem_z[slot] = a.z;
					pt_count++;
				end
			end
			REQ_REVERSE: begin
				if (pt_count > 0)
					pt_rev = !pt_rev;
				a.status = STS_REVERSED;
			end
			REQ_READ: begin
				if (int'(it.ridx) < pt_count) begin
					p = slot_of(int'(it.ridx));
					a.status = STS_READ_OK;
					a.x = mem_x[p];
					a.y = mem_y[p];
					a.z = mem_z[p];
				end
			end
			default: ;
		endcase
		a.count = CNT_W'(pt_count);
	endtask

	task automatic report_mismatch(input string msg);
		if (errors < 40)
			$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
				results_seen, name, got, want));
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !item_taken) begin
			// hold until taken
		end else if (item_q.size() > 0 && (quiet || $urandom_range(99) >= 8)) begin
			cur_item = item_q.pop_front();
			s_tvalid <= 1'b1;
			s_tuser <= cur_item.req;
			s_tdata <= {{(S_W - IDX_W - 3 * CW){1'b0}}, cur_item.z, cur_item.y, cur_item.x,
				cur_item.ridx};
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_LEN;
			holds_served <= holds_served + 1;
		end else begin
			m_tready <= quiet || $urandom_range(99) >= 8;
		end
	end

	// monitor
	always @(posedge clk) begin
		store_answer_t want;
		item_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (answer_q.size() == 0) begin
				report_mismatch($sformatf("result %0d with no request waiting", results_seen));
			end else begin
				want = answer_q.pop_front();
				check_field("status", 32'(m_tuser), 32'(want.status));
				check_field("match_index", 32'(m_tdata[9:0]), 32'(want.match));
				check_field("point_count", 32'(m_tdata[20:10]), 32'(want.count));
				check_field("out_x", 32'(m_tdata[44:21]), 32'(want.x));
				check_field("out_y", 32'(m_tdata[68:45]), 32'(want.y));
				check_field("out_z", 32'(m_tdata[92:69]), 32'(want.z));
			end
			results_seen++;
		end
		if (arst_n && s_tvalid && s_tready) begin
			advance_store(cur_item, want);
			answer_q.insert(answer_q.size(), want);
			items_taken++;
		end
	end

	task automatic push_item(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] ridx,
		input logic [CW-1:0] x, y, z);
		req_item_t it;
		point_t p;
		it.req = req;
		it.ridx = ridx;
		it.x = x;
		it.y = y;
		it.z = z;
		item_q.insert(item_q.size(), it);
		items_pushed++;
		if (req == REQ_ADD) begin
			p.x = x;
			p.y = y;
			p.z = z;
			seen_q.insert(seen_q.size(), p);
			if (plan_count < DEPTH)
				plan_count++;
		end
	endtask

	function automatic logic [CW-1:0] pick_coord();
		case ($urandom_range(9))
			0: return CMAX;
			1: return CMIN;
			2: return '0;
			default: return CW'($urandom());
		endcase
	endfunction

	task automatic push_random_item(input int add_pct);
		int r, k, m, rest;
		logic [IDX_W-1:0] ridx;
		point_t p;
		r = $urandom_range(99);
		rest = 100 - add_pct;
		ridx = IDX_W'($urandom());
		p.x = pick_coord();
		p.y = pick_coord();
		p.z = pick_coord();
		if (r < add_pct) begin
			// points near an earlier one give loop-backs
			if (seen_q.size() > 0 && $urandom_range(99) < 45) begin
				k = $urandom_range(seen_q.size() - 1);
				m = 1 << $urandom_range(14);
				p.x = CW'(seen_q[k].x + $urandom_range(2 * m) - m);
				p.y = CW'(seen_q[k].y + $urandom_range(2 * m) - m);
				p.z = CW'(seen_q[k].z + $urandom_range(2 * m) - m);
			end
			push_item(REQ_ADD, ridx, p.x, p.y, p.z);
		end else if (r < add_pct + rest * 3 / 5) begin
			if (plan_count > 0 && $urandom_range(99) < 85)
				ridx = IDX_W'($urandom_range(plan_count - 1));
			push_item(REQ_READ, ridx, p.x, p.y, p.z);
		end else if (r < add_pct + rest * 17 / 20) begin
			push_item(REQ_REVERSE, ridx, p.x, p.y, p.z);
		end else begin
			push_item(REQ_UNUSED, ridx, p.x, p.y, p.z);
		end
	endtask

	task automatic settle();
		while (!(items_taken == items_pushed && answer_q.size() == 0))
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input longint unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value[CFG_DATA_W-1:0];
		case (addr)
			REG_LOOP_ENABLE:   cfg_loop = value[0];
			REG_MIN_INDEX_GAP: cfg_gap = int'(value[GAP_W-1:0]);
			REG_LOOP_DIST_SQ:  cfg_thr = 64'(value[THR_W-1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input bit en, input int gap, input longint unsigned thr);
		settle();
		write_reg(REG_LOOP_ENABLE, 64'(en));
		write_reg(REG_MIN_INDEX_GAP, 64'(gap));
		write_reg(REG_LOOP_DIST_SQ, thr);
	endtask

	initial begin
		int gap;
		longint unsigned thr;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty store, looping off
		push_item(REQ_READ, 10'd0, CMAX, CMAX, CMAX);
		push_item(REQ_REVERSE, 10'd1023, '0, '0, '0);
		push_item(REQ_UNUSED, 10'd1023, CMIN, CMAX, '1);
		push_item(REQ_ADD, 10'd1023, CMAX, CMIN, '0);
		push_item(REQ_ADD, 10'd0, CMIN, CMAX, '1);
		push_item(REQ_READ, 10'd1, '0, '0, '0);
		push_item(REQ_READ, 10'd2, '0, '0, '0);
		push_item(REQ_READ, 10'd1023, '1, '1, '1);
		push_item(REQ_REVERSE, 10'd0, '0, '0, '0);
		push_item(REQ_READ, 10'd0, '0, '0, '0);
		push_item(REQ_ADD, 10'd0, 24'd1, 24'd2, 24'd3);
		push_item(REQ_READ, 10'd0, '0, '0, '0);
		push_item(REQ_READ, 10'd2, '0, '0, '0);
		push_item(REQ_REVERSE, 10'd0, '0, '0, '0);
		push_item(REQ_READ, 10'd2, '0, '0, '0);

		// whole-store search, widest threshold, extreme differences
		set_config(1'b1, 0, THR_MAX);
		push_item(REQ_ADD, 10'd0, CMIN, CMIN, CMIN);
		push_item(REQ_ADD, 10'd0, CMAX, CMAX, CMAX);
		set_config(1'b1, DEPTH, THR_MAX);
		push_item(REQ_ADD, 10'd0, 24'd5, 24'd5, 24'd5);
		set_config(1'b1, 3, 100);
		push_item(REQ_ADD, 10'd0, 24'd4, 24'd2, 24'd7);
		push_item(REQ_ADD, 10'd0, 24'd5, 24'd6, 24'd5);
		set_config(1'b1, 0, 0);
		push_item(REQ_ADD, 10'd0, 24'd1, 24'd2, 24'd3);
		set_config(1'b0, 0, 0);
		push_item(REQ_ADD, 10'd0, CMAX, CMAX, CMAX);
		push_item(REQ_READ, 10'd0, '0, '0, '0);

		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(4))
				0: gap = 0;
				1: gap = 1;
				2: gap = $urandom_range(2, 16);
				3: gap = $urandom_range(plan_count);
				default: gap = DEPTH;
			endcase
			case ($urandom_range(5))
				0: thr = 0;
				1: thr = 1;
				2: thr = 64'd1 << 20;
				3: thr = 64'd1 << 32;
				4: thr = {$urandom(), $urandom()} % (THR_MAX + 1);
				default: thr = THR_MAX;
			endcase
			set_config(ph != 3, gap, thr);
			quiet = (ph == 2);
			for (int n = 0; n < 92; n++)
				push_random_item(50);
			if (ph == 4)
				holds_asked++;
		end

		// gap above count, edge reads, then whole-store search
		set_config(1'b1, DEPTH, THR_MAX);
		quiet = 1'b0;
		push_item(REQ_ADD, 10'd0, '0, '0, '0);
		push_item(REQ_READ, 10'd1023, '0, '0, '0);
		push_item(REQ_READ, 10'd0, '0, '0, '0);
		push_item(REQ_REVERSE, 10'd0, '0, '0, '0);
		push_item(REQ_READ, 10'd1023, '0, '0, '0);
		push_item(REQ_UNUSED, 10'd0, '0, '0, '0);
		set_config(1'b1, 0, THR_MAX);
		push_item(REQ_ADD, 10'd0, CMIN, CMAX, CMIN);
		push_item(REQ_ADD, 10'd0, CMAX, CMIN, CMAX);
		for (int n = 0; n < 10; n++)
			push_random_item(30);

		settle();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
